// File: design/bsdc_pkg.sv
// Shared constants, types and helpers for the bounded stack with duplicate count.
// No dependencies; every other file of the block imports this package.
package bsdc_pkg;

    localparam int DEPTH     = 16;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = 4;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;
    localparam int VAL_W     = 32;
    localparam int OUT_CNT_W = 5;
    localparam int SUM_W     = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 2;

    typedef logic [ACT_W-1:0]   action_t;
    typedef logic [STAT_W-1:0]  status_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic signed [VAL_W-1:0] value_t;
    typedef logic [OUT_CNT_W-1:0] out_cnt_t;

    // action codes
    localparam action_t ACT_PUSH = 2'd0;
    localparam action_t ACT_POP  = 2'd1;
    localparam action_t ACT_GET  = 2'd2;

    // status codes
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_POP_EMPTY = 2'd1;
    localparam status_t ST_GET_RANGE = 2'd2;

    // storage write request
    typedef struct packed {
        logic   en;
        addr_t  addr;
        value_t value;
        cnt_t   dup;
    } store_wr_t;

    // storage read request
    typedef struct packed {
        logic  en;
        addr_t addr;
    } store_rd_t;

    // step a slot pointer down by one, wrapping at the bottom of the ring
    function automatic addr_t addr_dec(addr_t a);
        addr_t r;
        if (a == '0) begin
            r = ADDR_W'(DEPTH - 1);
        end else begin
            r = a - addr_t'(1);
        end
        return r;
    endfunction

    // step a slot pointer up by one, wrapping at the top of the ring
    function automatic addr_t addr_inc(addr_t a);
        addr_t r;
        if (a == ADDR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = a + addr_t'(1);
        end
        return r;
    endfunction

    // report a count on the 5-bit result fields (masked when wider)
    function automatic out_cnt_t out_cnt(cnt_t c);
        logic [OUT_CNT_W+CNT_W-1:0] wide;
        wide = {{OUT_CNT_W{1'b0}}, c};
        return wide[OUT_CNT_W-1:0];
    endfunction

endpackage

// File: design/bsdc_store.sv
// Entry storage: value and duplicate-count ring, one write and one read port.
// Read data is registered. Depends on bsdc_pkg.
module bsdc_store (
    input  logic                aclk,
    input  bsdc_pkg::store_wr_t wr,
    input  bsdc_pkg::store_rd_t rd,
    output bsdc_pkg::value_t    rd_value,
    output bsdc_pkg::cnt_t      rd_dup
);
    import bsdc_pkg::*;

    value_t val_mem [DEPTH];
    cnt_t   dup_mem [DEPTH];
    value_t rd_value_reg;
    cnt_t   rd_dup_reg;

    // write the pushed word
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            val_mem[wr.addr] <= wr.value;
            dup_mem[wr.addr] <= wr.dup;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_value_reg <= val_mem[rd.addr];
            rd_dup_reg   <= dup_mem[rd.addr];
        end
    end

    assign rd_value = rd_value_reg;
    assign rd_dup   = rd_dup_reg;

endmodule

// File: design/bsdc_dup_count.sv
// Shared comparator and counter: counts stored entries equal to the key.
// One compare per cycle while enabled. Depends on bsdc_pkg.
module bsdc_dup_count (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             en,
    input  bsdc_pkg::value_t key,
    input  bsdc_pkg::value_t data,
    output bsdc_pkg::cnt_t   count
);
    import bsdc_pkg::*;

    cnt_t count_reg;
    cnt_t count_next;

    // clear at the start of a push, bump on every match
    always_comb begin
        count_next = count_reg;
        if (clear) begin
            count_next = '0;
        end else if (en && (data == key)) begin
            count_next = count_reg + cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// File: design/bounded_stack_with_duplicate_count_unit.sv
// Top level of the bounded stack with duplicate count: sequencer and result register.
// Depends on bsdc_pkg, bsdc_store and bsdc_dup_count.
//
// Usage:
//   Input channel s_valid/s_ready carries one word: s_action (push, pop, get),
//   s_value (pushed value) and s_index (depth from the top for get).
//   Result channel m_valid/m_ready returns one word per input word: m_status,
//   m_entry_value, m_entry_duplicates and m_size.
//   A push reads every held entry through one comparator, one entry a cycle,
//   then writes the new entry with its duplicate count; on an empty stack it
//   writes at once. Pop and in-range get make one storage read; error cases and
//   the unused code go straight to the result.
//   One word is worked on at a time: s_ready is high only while the
//   sequencer is idle, so a new word is taken only after the previous one is
//   finished. A finished result waits in the output register; the next word
//   may be taken meanwhile, and its result is held back until the previous one
//   has been taken.
//   When full, a push overwrites the oldest entry.
//   Reset (aresetn low, synchronous) empties the stack and drops any pending
//   result; storage contents are not cleared and are never read before written.
module bounded_stack_with_duplicate_count_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bsdc_pkg::action_t    s_action,
    input  bsdc_pkg::value_t     s_value,
    input  bsdc_pkg::idx_t       s_index,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bsdc_pkg::status_t    m_status,
    output bsdc_pkg::value_t     m_entry_value,
    output bsdc_pkg::out_cnt_t   m_entry_duplicates,
    output bsdc_pkg::out_cnt_t   m_size
);
    import bsdc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_WRITE = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t   state_reg, state_next;
    addr_t    top_reg, top_next;
    cnt_t     count_reg, count_next;
    addr_t    scan_ptr_reg, scan_ptr_next;
    cnt_t     scan_left_reg, scan_left_next;
    logic     cmp_valid_reg;
    action_t  act_reg, act_next;
    value_t   key_reg, key_next;
    status_t  res_status_reg, res_status_next;
    value_t   res_value_reg, res_value_next;
    cnt_t     res_dup_reg, res_dup_next;
    logic     m_valid_reg, m_valid_next;
    status_t  m_status_reg, m_status_next;
    value_t   m_value_reg, m_value_next;
    out_cnt_t m_dup_reg, m_dup_next;
    out_cnt_t m_size_reg, m_size_next;

    store_wr_t wr;
    store_rd_t rd;
    value_t    rd_value;
    cnt_t      rd_dup;
    logic      dup_clear;
    cnt_t      dup_count;

    logic               accept;
    logic               load_out;
    logic [SUM_W-1:0]   get_sum;
    logic [SUM_W-1:0]   get_wrap;
    addr_t              get_slot;
    logic               get_in_range;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // slot of the entry at depth s_index: top + DEPTH - 1 - index, folded once
    assign get_sum  = SUM_W'(top_reg) + SUM_W'(DEPTH - 1) - SUM_W'(s_index);
    assign get_wrap = (get_sum >= SUM_W'(DEPTH)) ? get_sum - SUM_W'(DEPTH) : get_sum;
    assign get_slot = get_wrap[ADDR_W-1:0];
    assign get_in_range = ({{CNT_W{1'b0}}, s_index} < {{IDX_W{1'b0}}, count_reg});

    bsdc_store u_store (
        .aclk     (aclk),
        .wr       (wr),
        .rd       (rd),
        .rd_value (rd_value),
        .rd_dup   (rd_dup)
    );

    bsdc_dup_count u_dup_count (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (dup_clear),
        .en      (cmp_valid_reg),
        .key     (key_reg),
        .data    (rd_value),
        .count   (dup_count)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        top_next        = top_reg;
        count_next      = count_reg;
        scan_ptr_next   = scan_ptr_reg;
        scan_left_next  = scan_left_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_dup_next    = res_dup_reg;
        dup_clear       = 1'b0;
        rd              = '0;
        wr              = '0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    act_next        = s_action;
                    key_next        = s_value;
                    res_status_next = ST_OK;
                    res_value_next  = '0;
                    res_dup_next    = '0;
                    case (s_action)
                        ACT_PUSH: begin
                            dup_clear      = 1'b1;
                            scan_ptr_next  = addr_dec(top_reg);
                            scan_left_next = count_reg;
                            state_next     = (count_reg == '0) ? S_WRITE : S_SCAN;
                        end
                        ACT_POP: begin
                            if (count_reg == '0) begin
                                res_status_next = ST_POP_EMPTY;
                                state_next      = S_DONE;
                            end else begin
                                rd.en      = 1'b1;
                                rd.addr    = addr_dec(top_reg);
                                state_next = S_READ;
                            end
                        end
                        ACT_GET: begin
                            if (!get_in_range) begin
                                res_status_next = ST_GET_RANGE;
                                state_next      = S_DONE;
                            end else begin
                                rd.en      = 1'b1;
                                rd.addr    = get_slot;
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read a cycle, newest entry first
                rd.en          = 1'b1;
                rd.addr        = scan_ptr_reg;
                scan_ptr_next  = addr_dec(scan_ptr_reg);
                scan_left_next = scan_left_reg - cnt_t'(1);
                if (scan_left_reg == cnt_t'(1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last compare lands this cycle
                state_next = S_WRITE;
            end
            S_WRITE: begin
                wr.en          = 1'b1;
                wr.addr        = top_reg;
                wr.value       = key_reg;
                wr.dup         = dup_count;
                res_value_next = key_reg;
                res_dup_next   = dup_count;
                top_next       = addr_inc(top_reg);
                if (count_reg != CNT_W'(DEPTH)) begin
                    count_next = count_reg + cnt_t'(1);
                end
                state_next = S_DONE;
            end
            S_READ: begin
                res_value_next = rd_value;
                res_dup_next   = rd_dup;
                if (act_reg == ACT_POP) begin
                    top_next   = addr_dec(top_reg);
                    count_next = count_reg - cnt_t'(1);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register: load a finished result, drop it once taken
    always_comb begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_dup_next    = m_dup_reg;
        m_size_next   = m_size_reg;
        if (load_out) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_value_next  = res_value_reg;
            m_dup_next    = out_cnt(res_dup_reg);
            m_size_next   = out_cnt(count_reg);
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            cmp_valid_reg <= (state_reg == S_SCAN);
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        scan_ptr_reg   <= scan_ptr_next;
        scan_left_reg  <= scan_left_next;
        act_reg        <= act_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_dup_reg    <= res_dup_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_dup_reg      <= m_dup_next;
        m_size_reg     <= m_size_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_entry_value      = m_value_reg;
    assign m_entry_duplicates = m_dup_reg;
    assign m_size             = m_size_reg;

endmodule
